// ===== hw/rtl/spi_flash_command_planner_assert.svh =====
// ----------------------------------------------------------------------------
// spi flash command planner assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SPI_FLASH_COMMAND_PLANNER_ASSERT_SVH
`define SPI_FLASH_COMMAND_PLANNER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define SFCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SFCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SFCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/sfcp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcp_pkg
// shared types, codes and constants of the spi flash command planner
// ----------------------------------------------------------------------------
package sfcp_pkg;

  localparam int ADDR_W = 24;
  localparam int LEN_W  = 25;
  localparam int CNT_W  = 16;
  localparam int SUM_W  = ADDR_W + 2;

  localparam int PAGE_BYTES_DEF      = 256;
  localparam int SECTOR_BYTES_DEF    = 4096;
  localparam int MAX_WRITE_BYTES_DEF = 4096;
  localparam int ADDRESS_BITS_DEF    = 24;
  localparam int MAX_RESULTS         = 64;

  localparam logic [LEN_W-1:0] FLASH_SIZE_RESET = LEN_W'(256 * 1024);
  localparam logic [LEN_W-1:0] READ_LEN_MAX     = LEN_W'(16'hFFFF);

  // flash command bytes
  localparam logic [7:0] CMD_READ    = 8'h03;
  localparam logic [7:0] CMD_PROGRAM = 8'h02;
  localparam logic [7:0] CMD_ERASE   = 8'h20;

  // request kinds
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ERASE = 2'd2,
    OP_RSVD  = 2'd3
  } sfcp_op_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [ADDR_W-1:0] start_address;
    logic [LEN_W-1:0]  length;
  } sfcp_req_t;

  typedef struct packed {
    logic              command_valid;
    logic [7:0]        flash_opcode;
    logic [ADDR_W-1:0] flash_address;
    logic [CNT_W-1:0]  byte_count;
    logic              status;
    logic              last;
  } sfcp_res_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch request
    logic calc;   // register end and rounded bounds
    logic start;  // set up emission
    logic step;   // emit one result into output register
  } sfcp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;        // request rejected
    logic empty;      // request yields no result
    logic slot_free;  // output register can take a result
    logic last;       // current result is the final one
  } sfcp_sts_t;

endpackage

// ===== hw/rtl/sfcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfcp_ctrl
// request sequencer: intake, bound check, then one result per free slot
// ----------------------------------------------------------------------------
module sfcp_ctrl
  import sfcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sfcp_sts_t sts,
  output sfcp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_CHECK,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts.bad && sts.empty) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.start = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.step = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ===== hw/rtl/sfcp_dpath.sv =====
// ----------------------------------------------------------------------------
// sfcp_dpath
// request registers, range and count checks, page and sector walk,
// size register and output register
// ----------------------------------------------------------------------------
`include "spi_flash_command_planner_assert.svh"

module sfcp_dpath
  import sfcp_pkg::*;
#(
  parameter int PAGE_BYTES      = PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES    = SECTOR_BYTES_DEF,
  parameter int MAX_WRITE_BYTES = MAX_WRITE_BYTES_DEF,
  parameter int ADDRESS_BITS    = ADDRESS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sfcp_req_t        in_data,
  input  logic             cfg_write_en,
  input  logic [LEN_W-1:0] cfg_write_data,
  input  logic             out_ready,
  output logic             out_valid,
  output sfcp_res_t        out_data,
  input  sfcp_cmd_t        cmd,
  output sfcp_sts_t        sts
);

  localparam int PG_W   = $clog2(PAGE_BYTES);
  localparam int SEC_W  = $clog2(SECTOR_BYTES);
  localparam int ROOM_W = PG_W + 1;
  localparam int REM_W  = $clog2(MAX_WRITE_BYTES + 1);
  localparam int CW     = (ROOM_W > REM_W) ? ROOM_W : REM_W;
  localparam int AW1    = ADDR_W + 1;

  localparam logic [SUM_W-1:0] PAGE_M1   = SUM_W'(PAGE_BYTES - 1);
  localparam logic [SUM_W-1:0] SECT_M1   = SUM_W'(SECTOR_BYTES - 1);
  localparam logic [SUM_W-1:0] SECT_MASK = ~SECT_M1;
  localparam logic [SUM_W-1:0] SECT_SZ   = SUM_W'(SECTOR_BYTES);
  localparam logic [SUM_W-1:0] RES_MAX   = SUM_W'(MAX_RESULTS);
  localparam logic [LEN_W-1:0] WR_MAX    = LEN_W'(MAX_WRITE_BYTES);
  localparam logic [LEN_W-1:0] SPAN      = LEN_W'(64'd1 << ADDRESS_BITS);
  localparam logic [ROOM_W-1:0] PAGE_SZ  = ROOM_W'(PAGE_BYTES);

  typedef enum logic [1:0] {
    EM_INVALID,
    EM_READ,
    EM_PROG,
    EM_ERASE
  } emit_t;

  logic [LEN_W-1:0]  flash_size_r;
  logic [1:0]        op_r;
  logic [ADDR_W-1:0] start_r;
  logic [LEN_W-1:0]  len_r;
  logic [SUM_W-1:0]  end_r;
  logic [SUM_W-1:0]  span_r;
  logic [SUM_W-1:0]  stop_r;
  emit_t             mode_r;
  logic [AW1-1:0]    addr_r;
  logic [REM_W-1:0]  rem_r;
  logic              out_valid_r;
  sfcp_res_t         out_data_r;

  logic [LEN_W-1:0]  limit;
  logic [SUM_W-1:0]  first;
  logic [SUM_W-1:0]  pages;
  logic [SUM_W-1:0]  sectors;
  logic              bad;
  logic              empty;
  logic [ROOM_W-1:0] room;
  logic [CW-1:0]     rem_ext;
  logic [CW-1:0]     room_ext;
  logic [CW-1:0]     chunk;
  logic              prog_last;
  logic [SUM_W-1:0]  after;
  logic              erase_last;
  sfcp_res_t         res;
  logic              res_last;

  // request checks, valid in the check cycle
  always_comb begin
    limit   = (flash_size_r > SPAN) ? SPAN : flash_size_r;
    first   = SUM_W'(start_r) & SECT_MASK;
    pages   = span_r >> PG_W;
    sectors = (stop_r - first) >> SEC_W;
    bad     = (op_r == OP_RSVD) || (end_r > SUM_W'(limit));
    empty   = 1'b0;
    case (op_r)
      OP_READ:  bad = bad || (len_r > READ_LEN_MAX);
      OP_WRITE: begin
        bad   = bad || (len_r > WR_MAX) || (pages > RES_MAX);
        empty = (len_r == '0);
      end
      OP_ERASE: begin
        bad   = bad || (sectors > RES_MAX);
        empty = (stop_r == first);
      end
      default: ;
    endcase
  end

  // page chunk and sector walk
  always_comb begin
    room       = PAGE_SZ - ROOM_W'(addr_r[PG_W-1:0]);
    rem_ext    = CW'(rem_r);
    room_ext   = CW'(room);
    chunk      = (rem_ext < room_ext) ? rem_ext : room_ext;
    prog_last  = (rem_ext <= room_ext);
    after      = SUM_W'(addr_r) + SECT_SZ;
    erase_last = (after >= stop_r);
  end

  // result for the current step
  always_comb begin
    res      = '0;
    res_last = 1'b1;
    case (mode_r)
      EM_INVALID: begin
        res.status = 1'b1;
        res.last   = 1'b1;
      end
      EM_READ: begin
        res.command_valid = 1'b1;
        res.flash_opcode  = CMD_READ;
        res.flash_address = start_r;
        res.byte_count    = len_r[CNT_W-1:0];
        res.last          = 1'b1;
      end
      EM_PROG: begin
        res.command_valid = 1'b1;
        res.flash_opcode  = CMD_PROGRAM;
        res.flash_address = addr_r[ADDR_W-1:0];
        res.byte_count    = CNT_W'(chunk);
        res.last          = prog_last;
        res_last          = prog_last;
      end
      EM_ERASE: begin
        res.command_valid = 1'b1;
        res.flash_opcode  = CMD_ERASE;
        res.flash_address = addr_r[ADDR_W-1:0];
        res.last          = erase_last;
        res_last          = erase_last;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_size_r <= FLASH_SIZE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        flash_size_r <= cfg_write_data;
      end
      if (cmd.step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request, bound and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.operation;
      start_r <= in_data.start_address;
      len_r   <= in_data.length;
    end
    if (cmd.calc) begin
      end_r  <= SUM_W'(start_r) + SUM_W'(len_r);
      span_r <= SUM_W'(start_r[PG_W-1:0]) + SUM_W'(len_r) + PAGE_M1;
      stop_r <= (SUM_W'(start_r) + SUM_W'(len_r) + SECT_M1) & SECT_MASK;
    end
    if (cmd.start) begin
      rem_r <= len_r[REM_W-1:0];
      if (bad) begin
        mode_r <= EM_INVALID;
        addr_r <= AW1'(start_r);
      end else if (op_r == OP_READ) begin
        mode_r <= EM_READ;
        addr_r <= AW1'(start_r);
      end else if (op_r == OP_WRITE) begin
        mode_r <= EM_PROG;
        addr_r <= AW1'(start_r);
      end else begin
        mode_r <= EM_ERASE;
        addr_r <= first[AW1-1:0];
      end
    end
    if (cmd.step) begin
      out_data_r <= res;
      if (mode_r == EM_PROG) begin
        addr_r <= addr_r + AW1'(chunk);
        rem_r  <= rem_r - REM_W'(chunk);
      end else if (mode_r == EM_ERASE) begin
        addr_r <= after[AW1-1:0];
      end
    end
  end

  assign sts.bad       = bad;
  assign sts.empty     = empty;
  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.last      = res_last;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  // checks on the walk
  `SFCP_ASSERT_IMP(a_step_slot, clk, rst_n, cmd.step, !out_valid_r || out_ready, "step into busy output register")
  `SFCP_ASSERT_IMP(a_prog_rem, clk, rst_n, cmd.step && mode_r == EM_PROG, rem_r != '0, "page program with nothing left")
  `SFCP_ASSERT_IMP(a_erase_bound, clk, rst_n, cmd.step && mode_r == EM_ERASE, SUM_W'(addr_r) < stop_r, "sector erase past end")
  `SFCP_ASSERT_NXT(a_step_valid, clk, rst_n, cmd.step, out_valid_r, "stepped result not presented")

endmodule

// ===== hw/rtl/spi_flash_command_planner.sv =====
// ----------------------------------------------------------------------------
// spi_flash_command_planner
// turns valid read, write and erase requests into spi nor flash commands:
// one read, page programs split at page edges, or sector erases
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | beat
//  in_     | input     | in_valid / in_ready   | one request (sfcp_req_t)
//  out_    | output    | out_valid / out_ready | one command result (sfcp_res_t)
//  cfg_    | input     | cfg_write_en          | flash size in bytes
//
//  a request passes intake, bound calculation and check, then one result per
//  cycle while the output is free (up to 64); the single sequencer sets this
//  the next request is taken in the cycle after its last result is registered
//  out_ready low holds the output register and pauses the walk
//  reset is synchronous, active low; flash size returns to 256 KiB
// ----------------------------------------------------------------------------
module spi_flash_command_planner
  import sfcp_pkg::*;
#(
  parameter int PAGE_BYTES      = PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES    = SECTOR_BYTES_DEF,
  parameter int MAX_WRITE_BYTES = MAX_WRITE_BYTES_DEF,
  parameter int ADDRESS_BITS    = ADDRESS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfcp_req_t        in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sfcp_res_t        out_data,
  input  logic             cfg_write_en,
  input  logic [LEN_W-1:0] cfg_write_data
);

  sfcp_cmd_t cmd;
  sfcp_sts_t sts;

  // sequencer
  sfcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  sfcp_dpath #(
    .PAGE_BYTES      (PAGE_BYTES),
    .SECTOR_BYTES    (SECTOR_BYTES),
    .MAX_WRITE_BYTES (MAX_WRITE_BYTES),
    .ADDRESS_BITS    (ADDRESS_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data        (in_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ===== sim/spi_flash_command_planner_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi flash command planner checker
// follows the request, result and flash size ports, plans the flash commands
// of every accepted request and compares each result beat against them in
// order, counting every mismatch
// ----------------------------------------------------------------------------
module spi_flash_command_planner_checker
  import sfcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  sfcp_req_t        in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  sfcp_res_t        out_data,
  input  logic             cfg_write_en,
  input  logic [LEN_W-1:0] cfg_write_data,
  output int               fail_count,
  output int               pending
);

  localparam int          REPORT_MAX = 40;
  localparam logic [31:0] ADDR_SPAN  = 32'd1 << ADDRESS_BITS_DEF;

  logic [LEN_W-1:0] flash_size;
  sfcp_res_t        expected_cmds[$];
  int               result_beats;

  initial begin
    fail_count   = 0;
    pending      = 0;
    result_beats = 0;
    flash_size   = FLASH_SIZE_RESET;
  end

  // one line per mismatch, quiet after the first 40
  task automatic report_mismatch(input string msg);
    if (fail_count < REPORT_MAX) begin
      $display("%0t checker: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                result_beats, name, got, want));
    end
  endtask

  function automatic sfcp_res_t make_cmd(input logic [7:0] opc, input logic [31:0] addr,
                                         input logic [31:0] count, input logic fin);
    sfcp_res_t r;
    r.command_valid = 1'b1;
    r.flash_opcode  = opc;
    r.flash_address = addr[ADDR_W-1:0];
    r.byte_count    = count[CNT_W-1:0];
    r.status        = 1'b0;
    r.last          = fin;
    return r;
  endfunction

  // expected commands of one request at the current flash size
  function automatic void plan_request(input sfcp_req_t req);
    logic [31:0] base;
    logic [31:0] len;
    logic [31:0] end_a;
    logic [31:0] limit;
    logic [31:0] cur;
    logic [31:0] left;
    logic [31:0] chunk;
    logic [31:0] stop;
    logic        bad;
    sfcp_res_t   cmds[$];
    sfcp_res_t   reject;
    base  = 32'(req.start_address);
    len   = 32'(req.length);
    end_a = base + len;
    limit = (32'(flash_size) < ADDR_SPAN) ? 32'(flash_size) : ADDR_SPAN;
    bad   = (end_a > limit) || (req.operation == OP_RSVD);
    if (!bad) begin
      case (sfcp_op_t'(req.operation))
        OP_READ: begin
          // byte_count cannot carry longer reads
          if (len > 32'(READ_LEN_MAX)) bad = 1'b1;
          else cmds.push_back(make_cmd(CMD_READ, base, len, 1'b1));
        end
        OP_WRITE: begin
          // page programs, split at every page edge
          if (len > MAX_WRITE_BYTES_DEF) bad = 1'b1;
          cur  = base;
          left = len;
          while (!bad && left != 0) begin
            chunk = PAGE_BYTES_DEF - (cur % PAGE_BYTES_DEF);
            if (chunk > left) chunk = left;
            if (cmds.size() >= MAX_RESULTS) begin
              bad = 1'b1;
            end else begin
              cmds.push_back(make_cmd(CMD_PROGRAM, cur, chunk, left == chunk));
              cur  = cur + chunk;
              left = left - chunk;
            end
          end
        end
        OP_ERASE: begin
          // whole sectors from start rounded down to end rounded up
          cur  = base - (base % SECTOR_BYTES_DEF);
          stop = end_a;
          if (stop % SECTOR_BYTES_DEF != 0) begin
            stop = stop + SECTOR_BYTES_DEF - (stop % SECTOR_BYTES_DEF);
          end
          if ((stop - cur) / SECTOR_BYTES_DEF > MAX_RESULTS) begin
            bad = 1'b1;
          end else begin
            while (cur < stop) begin
              cmds.push_back(make_cmd(CMD_ERASE, cur, 32'd0,
                                      cur + SECTOR_BYTES_DEF >= stop));
              cur = cur + SECTOR_BYTES_DEF;
            end
          end
        end
        default: bad = 1'b1;
      endcase
    end
    if (bad) begin
      reject        = '0;
      reject.status = 1'b1;
      reject.last   = 1'b1;
      expected_cmds.push_back(reject);
    end else begin
      foreach (cmds[i]) expected_cmds.push_back(cmds[i]);
    end
  endfunction

  // sample every port at the clock edge
  always @(posedge clk) begin : watch
    sfcp_res_t want;
    if (!rst_n) begin
      flash_size = FLASH_SIZE_RESET;
      expected_cmds.delete();
    end else begin
      if (cfg_write_en) flash_size = cfg_write_data;
      if (in_valid && in_ready) plan_request(in_data);
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected: %h",
                                    result_beats, out_data));
        end else begin
          want = expected_cmds.pop_front();
          check_field("command_valid", 32'(out_data.command_valid), 32'(want.command_valid));
          check_field("flash_opcode", 32'(out_data.flash_opcode), 32'(want.flash_opcode));
          check_field("flash_address", 32'(out_data.flash_address), 32'(want.flash_address));
          check_field("byte_count", 32'(out_data.byte_count), 32'(want.byte_count));
          check_field("status", 32'(out_data.status), 32'(want.status));
          check_field("last", 32'(out_data.last), 32'(want.last));
        end
        result_beats++;
      end
    end
    pending = expected_cmds.size();
  end

endmodule

// ===== sim/spi_flash_command_planner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi flash command planner testbench
// drives directed and random read, write and erase requests over several
// flash sizes with random idling on both channels and one long output
// hold-off; the checker beside the block plans and compares every result
// ----------------------------------------------------------------------------
module spi_flash_command_planner_tb;
  import sfcp_pkg::*;

  localparam int          PHASES         = 5;
  localparam int          PHASE_REQS     = 41;
  localparam int          HOLD_AT        = 60;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          DRAIN_CYCLES   = 16;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int unsigned FULL_SPAN      = 32'd1 << ADDRESS_BITS_DEF;

  logic             clk;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  sfcp_req_t        in_data        = '0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  sfcp_res_t        out_data;
  logic             cfg_write_en   = 1'b0;
  logic [LEN_W-1:0] cfg_write_data = '0;

  int               fail_count;
  int               pending;
  int               sent_count  = 0;
  int               idle_cycles = 0;
  bit               quiet       = 1'b0;
  bit               held_off    = 1'b0;
  logic [LEN_W-1:0] cur_size    = FLASH_SIZE_RESET;

  spi_flash_command_planner DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  spi_flash_command_planner_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic sfcp_req_t mk_req(input sfcp_op_t op, input logic [ADDR_W-1:0] addr,
                                       input logic [LEN_W-1:0] len);
    sfcp_req_t r;
    r.operation     = op;
    r.start_address = addr;
    r.length        = len;
    return r;
  endfunction

  // mostly well-formed requests inside the flash, some rejects and noise
  function automatic sfcp_req_t rand_req(input logic [LEN_W-1:0] fsize);
    int unsigned lim;
    int unsigned sel;
    int unsigned a;
    int unsigned l;
    sfcp_op_t    op;
    lim = (fsize > FULL_SPAN) ? FULL_SPAN : fsize;
    sel = $urandom_range(0, 99);
    a   = $urandom_range(0, lim - 1);
    if (sel < 30) begin
      op = OP_READ;
      l  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 70000) : $urandom_range(0, 600);
    end else if (sel < 65) begin
      op = OP_WRITE;
      l  = ($urandom_range(0, 9) == 0) ? $urandom_range(4000, 4200)
                                       : $urandom_range(0, 1100);
      if ($urandom_range(0, 3) == 0) a = a & ~32'hFF;
    end else if (sel < 90) begin
      op = OP_ERASE;
      l  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70 * 4096)
                                       : $urandom_range(0, 3 * 4096);
      if ($urandom_range(0, 2) == 0) a = a & ~32'hFFF;
    end else if (sel < 93) begin
      op = OP_RSVD;
      l  = $urandom_range(0, 4096);
    end else begin
      op = sfcp_op_t'($urandom_range(0, 3));
      a  = $urandom() & 32'hFF_FFFF;
      l  = $urandom() & 32'h1FF_FFFF;
    end
    // pull most requests back inside the flash
    if (sel < 90 && a + l > lim && $urandom_range(0, 4) != 0) begin
      a = (l >= lim) ? 0 : $urandom_range(0, lim - l);
    end
    return mk_req(op, ADDR_W'(a), LEN_W'(l));
  endfunction

  // offer one request beat and hold it until taken
  task automatic send_req(input sfcp_req_t req);
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    sent_count++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // new flash size once every result is out and the block has settled
  task automatic set_flash_size(input logic [LEN_W-1:0] size);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write_data <= size;
    cfg_write_en   <= 1'b1;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    cur_size = size;
  endtask

  // request side
  initial begin : stimulus
    int unsigned sz;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, flash size from reset
    send_req(mk_req(OP_READ, 24'h000000, 25'd0));
    send_req(mk_req(OP_READ, 24'h000100, 25'd65535));
    send_req(mk_req(OP_READ, 24'h000000, 25'd65536));
    send_req(mk_req(OP_READ, 24'h03FFFF, 25'd1));
    send_req(mk_req(OP_READ, 24'h03FFFF, 25'd2));
    send_req(mk_req(OP_WRITE, 24'h000010, 25'd0));
    send_req(mk_req(OP_WRITE, 24'h0000F0, 25'd300));
    send_req(mk_req(OP_WRITE, 24'h000000, 25'd4096));
    send_req(mk_req(OP_WRITE, 24'h000001, 25'd4096));
    send_req(mk_req(OP_WRITE, 24'h000000, 25'd4097));
    send_req(mk_req(OP_ERASE, 24'h001000, 25'd0));
    send_req(mk_req(OP_ERASE, 24'h001234, 25'd0));
    send_req(mk_req(OP_ERASE, 24'h000FFF, 25'd2));
    send_req(mk_req(OP_ERASE, 24'h000000, 25'd262144));
    send_req(mk_req(OP_RSVD, 24'h000000, 25'd1));
    send_req(mk_req(OP_READ, 24'hFFFFFF, 25'h1FFFFFF));

    // directed, whole address space
    set_flash_size(LEN_W'(FULL_SPAN));
    send_req(mk_req(OP_ERASE, 24'h000000, 25'(65 * 4096)));
    send_req(mk_req(OP_READ, 24'hFFFF00, 25'd256));
    send_req(mk_req(OP_WRITE, 24'hFFFFF0, 25'd16));
    send_req(mk_req(OP_ERASE, 24'hFFF000, 25'h1000));
    send_req(mk_req(OP_READ, 24'hFFFFFF, 25'd2));

    // directed, smallest flash
    set_flash_size(LEN_W'(256));
    send_req(mk_req(OP_READ, 24'h000000, 25'd256));
    send_req(mk_req(OP_WRITE, 24'h0000F0, 25'd16));
    send_req(mk_req(OP_ERASE, 24'h000080, 25'd0));
    send_req(mk_req(OP_ERASE, 24'h000000, 25'd0));

    // random phases, each at its own flash size
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       sz = $urandom_range(256, 16384);
        1:       sz = FULL_SPAN;
        2:       sz = $urandom_range(16384, FULL_SPAN);
        3:       sz = $urandom_range(256, FULL_SPAN);
        default: sz = $urandom_range(FULL_SPAN / 16, FULL_SPAN);
      endcase
      set_flash_size(LEN_W'(sz));
      for (int i = 0; i < PHASE_REQS; i++) begin
        if (p == PHASES - 1 && i >= PHASE_REQS / 2) quiet = 1'b1;
        send_req(rand_req(cur_size));
      end
    end

    // drain and verdict
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side: random stalls and one long hold-off to back the block up
  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held_off && sent_count >= HOLD_AT) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 15);
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

// ===== spi_flash_command_planner.f =====
+incdir+hw/rtl
hw/rtl/sfcp_pkg.sv
hw/rtl/sfcp_ctrl.sv
hw/rtl/sfcp_dpath.sv
hw/rtl/spi_flash_command_planner.sv
sim/spi_flash_command_planner_checker.sv
sim/spi_flash_command_planner_tb.sv
